>>> hdl/hase_pkg.sv
// Package of shared types, constants and helpers for the Hall angle and speed estimator.
package hase_pkg;

  localparam int SpeedWindow = 10;
  localparam int TrimLo      = 2;
  localparam int TrimCount   = 6;
  localparam logic [26:0] SpeedNum = 27'd100530965;

  localparam logic [2:0] CodeLow  = 3'd0;
  localparam logic [2:0] CodeHigh = 3'd7;
  localparam logic [2:0] RefCw    = 3'd2;
  localparam logic [2:0] RefCcw   = 3'd6;

  // Division by a constant as a product with a rounded-up reciprocal,
  // x / d = (x * R) >> s, exact for every 32-bit x.
  localparam logic [31:0] RecipSix   = 32'hAAAA_AAAB;  // s = 34
  localparam logic [31:0] RecipFive  = 32'hCCCC_CCCD;  // s = 34
  localparam logic [31:0] Recip625   = 32'hD1B7_1759;  // s = 41
  localparam logic [26:0] IncDivisor = 27'd625;
  localparam logic [21:0] IncRound   = 22'd312;

  // Input word of the item channel.
  typedef struct packed {
    logic        kind;
    logic [31:0] capture_count;
    logic [2:0]  hall_code;
  } in_word_t;

  // Result word of the result channel.
  typedef struct packed {
    logic [15:0] rotor_angle;
    logic [26:0] raw_speed;
    logic [26:0] filtered_speed;
    logic [29:0] angle_increment;
    logic        code_error;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input, start the item
    logic div_start;  // start the speed division
    logic div_step;   // one restoring division step
    logic sort_step;  // one compare/swap of the window sort
    logic mean_sum;   // add up the middle six sorted entries
    logic mean_mul;   // divide that sum by six
    logic filt_sum;   // form four times the mean plus the speed
    logic filt_mul;   // divide that sum by five
    logic inc_quo;    // filtered speed over 625
    logic inc_rem;    // scaled remainder of that division
    logic inc_fin;    // assemble the angle increment
    logic commit;     // write results into the output word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_item;
    logic need_speed;
    logic window_full;
  } stat_t;

  // Sector angle table, 1/8192 rad.
  function automatic logic [15:0] sector_angle(input logic ccw, input logic [2:0] code);
    logic [15:0] a;
    a = 16'd0;
    case ({ccw, code})
      4'b0001: a = 16'd28746;
      4'b0010: a = 16'd44786;
      4'b0011: a = 16'd35676;
      4'b0100: a = 16'd7610;
      4'b0101: a = 16'd17932;
      4'b0110: a = 16'd729;
      4'b1001: a = 16'd32940;
      4'b1010: a = 16'd48538;
      4'b1011: a = 16'd39821;
      4'b1100: a = 16'd16474;
      4'b1101: a = 16'd26059;
      4'b1110: a = 16'd6562;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/hase_stream_if.sv
// Valid/ready stream interface carrying one word of a given type.
interface hase_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/hase_ctrl.sv
// Controller state machine sequencing the estimator datapath.
module hase_ctrl
  import hase_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_DIV      = 4'd2;
  localparam logic [3:0] S_SORT     = 4'd3;
  localparam logic [3:0] S_MEAN_SUM = 4'd4;
  localparam logic [3:0] S_MEAN_MUL = 4'd5;
  localparam logic [3:0] S_FILT_SUM = 4'd6;
  localparam logic [3:0] S_FILT_MUL = 4'd7;
  localparam logic [3:0] S_INC_QUO  = 4'd8;
  localparam logic [3:0] S_INC_REM  = 4'd9;
  localparam logic [3:0] S_INC_FIN  = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state, state_next;
  logic [5:0] count, count_next;
  logic       full, full_next;

  // The result word has its own register, so a new item may enter while it waits.
  assign in_ready = (state == S_IDLE);
  assign out_valid = full;

  always_comb begin
    state_next = state;
    count_next = count;
    full_next = full;
    cmd = '0;
    if (full && out_ready) full_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.edge_item) begin
          if (stat.need_speed) begin
            cmd.div_start = 1'b1;
            count_next = 6'd0;
            state_next = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end else if (stat.window_full) begin
          count_next = 6'd0;
          state_next = S_SORT;
        end else begin
          state_next = S_FILT_SUM;
        end
      end
      S_SORT: begin
        // 45 compare/swap steps of a bubble sort.
        cmd.sort_step = 1'b1;
        count_next = count + 6'd1;
        if (count == 6'd44) begin
          state_next = S_MEAN_SUM;
        end
      end
      S_MEAN_SUM: begin
        cmd.mean_sum = 1'b1;
        state_next = S_MEAN_MUL;
      end
      S_MEAN_MUL: begin
        cmd.mean_mul = 1'b1;
        state_next = S_FILT_SUM;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next = count + 6'd1;
        if (count == 6'd31) state_next = S_DONE;
      end
      S_FILT_SUM: begin
        cmd.filt_sum = 1'b1;
        state_next = S_FILT_MUL;
      end
      S_FILT_MUL: begin
        cmd.filt_mul = 1'b1;
        state_next = S_INC_QUO;
      end
      S_INC_QUO: begin
        cmd.inc_quo = 1'b1;
        state_next = S_INC_REM;
      end
      S_INC_REM: begin
        cmd.inc_rem = 1'b1;
        state_next = S_INC_FIN;
      end
      S_INC_FIN: begin
        cmd.inc_fin = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!full || out_ready) begin
          cmd.commit = 1'b1;
          full_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= 6'd0;
      full <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      full <= full_next;
    end
  end

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE)
    else $error("item loaded outside the idle state");
  a_commit_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> full)
    else $error("commit did not fill the output word");
  a_sort_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT && count == 6'd44) |=> state == S_MEAN_SUM)
    else $error("sort did not end after 45 steps");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && count != 6'd31) |=> state == S_DIV)
    else $error("division left early");
`endif

endmodule

>>> hdl/hase_dpath.sv
// Datapath: accumulator, angle lookup, speed window, sorter, divider and filter arithmetic.
module hase_dpath
  import hase_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rotation_direction,
  input  in_word_t    in_word,
  input  cmd_t        cmd,
  output stat_t       stat,
  output out_word_t   out_word
);

  logic        kind;
  logic [2:0]  code;
  logic [31:0] acc;
  logic [26:0] speed, mean, filt;
  logic [15:0] angle;
  logic        err;
  logic [26:0] win [SpeedWindow];
  logic [26:0] srt [SpeedWindow];
  logic [3:0]  widx;
  logic [3:0]  sb, sa;
  // Divider registers: remainder, quotient/dividend, divisor.
  logic [32:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  // Staged operands of the mean, the filter and the increment.
  logic [29:0] msum;
  logic [29:0] fsum;
  logic [17:0] incq;
  logic [21:0] inc_low;
  logic [29:0] incr;

  logic [32:0] sum33;
  logic [31:0] acc_sat;
  logic [2:0]  ref_code;
  logic        code_bad;
  logic [29:0] mid_sum;
  logic [32:0] rem_sh, rem_sub;
  logic [63:0] quo_sh;
  logic [61:0] mean_prod;
  logic [61:0] filt_prod;
  logic [58:0] inc_prod;
  logic [26:0] inc_back;
  logic [26:0] inc_left;
  logic [53:0] low_prod;

  assign sum33 = {1'b0, acc} + {1'b0, in_word.capture_count};
  assign acc_sat = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
  assign ref_code = rotation_direction ? RefCcw : RefCw;
  assign code_bad = (code == CodeLow) || (code == CodeHigh);

  assign stat.edge_item = !kind;
  assign stat.need_speed = !code_bad && (code == ref_code);
  assign stat.window_full = (widx == 4'd0);

  assign mid_sum = 30'(srt[2]) + 30'(srt[3]) + 30'(srt[4]) + 30'(srt[5])
                 + 30'(srt[6]) + 30'(srt[7]);

  // One restoring division step on a 64-bit dividend.
  assign rem_sh = {rem[31:0], quo[63]};
  assign quo_sh = {quo[62:0], 1'b0};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // Divisions by six and by five as products with reciprocals.
  assign mean_prod = {32'd0, msum} * {30'd0, RecipSix};
  assign filt_prod = {32'd0, fsum} * {30'd0, RecipFive};

  // The increment filt*4096/625 is split into 4096*(filt/625) plus the
  // scaled remainder over 625, which keeps every operand within 32 bits.
  assign inc_prod = {32'd0, filt} * {27'd0, Recip625};
  assign inc_back = {9'd0, incq} * IncDivisor;
  assign inc_left = filt - inc_back;
  assign low_prod = {32'd0, inc_low} * {22'd0, Recip625};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      speed <= '0;
      angle <= '0;
      mean <= '0;
      filt <= '0;
      widx <= '0;
      kind <= 1'b0;
      code <= '0;
      err <= 1'b0;
      sb <= '0;
      sa <= '0;
      msum <= '0;
      fsum <= '0;
      incq <= '0;
      inc_low <= '0;
      incr <= '0;
    end else begin
      if (cmd.load) begin
        kind <= in_word.kind;
        code <= in_word.hall_code;
        sb <= '0;
        sa <= '0;
        if (!in_word.kind) begin
          acc <= acc_sat;
          err <= (in_word.hall_code == CodeLow) || (in_word.hall_code == CodeHigh);
          if (!((in_word.hall_code == CodeLow) || (in_word.hall_code == CodeHigh)))
            angle <= sector_angle(rotation_direction, in_word.hall_code);
        end else begin
          err <= 1'b0;
          win[widx] <= speed;
          widx <= (widx == 4'(SpeedWindow - 1)) ? 4'd0 : widx + 4'd1;
          // The tick that fills the window also copies it for sorting.
          if (widx == 4'(SpeedWindow - 1)) begin
            for (int i = 0; i < SpeedWindow - 1; i++) srt[i] <= win[i];
            srt[SpeedWindow - 1] <= speed;
          end
        end
      end
      // Speed division setup and steps.
      if (cmd.div_start) begin
        rem <= '0;
        if (acc == 32'd0) begin
          quo <= 64'(SpeedNum) << 32;
          dvs <= 32'd1;
        end else begin
          quo <= (64'(SpeedNum) + 64'(acc[31:1])) << 32;
          dvs <= acc;
        end
      end else if (cmd.div_step) begin
        if (!rem_sub[32]) begin
          rem <= rem_sub;
          quo <= quo_sh | 64'd1;
        end else begin
          rem <= rem_sh;
          quo <= quo_sh;
        end
      end
      // Bubble sort: one adjacent compare/swap a cycle over the copy.
      if (cmd.sort_step) begin
        if (srt[sb] > srt[sb + 4'd1]) begin
          srt[sb] <= srt[sb + 4'd1];
          srt[sb + 4'd1] <= srt[sb];
        end
        if (sb == 4'(SpeedWindow - 2) - sa) begin
          sb <= '0;
          sa <= sa + 4'd1;
        end else begin
          sb <= sb + 4'd1;
        end
      end
      // Trimmed mean, filter and increment, one stage a cycle.
      if (cmd.mean_sum) msum <= mid_sum + 30'd3;
      if (cmd.mean_mul) mean <= mean_prod[60:34];
      if (cmd.filt_sum) fsum <= {1'b0, mean, 2'b00} + {3'd0, speed} + 30'd2;
      if (cmd.filt_mul) filt <= filt_prod[60:34];
      if (cmd.inc_quo) incq <= inc_prod[58:41];
      if (cmd.inc_rem) inc_low <= {inc_left[9:0], 12'd0} + IncRound;
      if (cmd.inc_fin) incr <= {incq, 12'd0} + {17'd0, low_prod[53:41]};
      // A reference edge takes the new speed and restarts the period sum.
      if (cmd.commit && !kind && stat.need_speed) begin
        speed <= quo[26:0];
        acc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_word.rotor_angle <= angle;
      out_word.raw_speed <= (!kind && stat.need_speed) ? quo[26:0] : speed;
      out_word.filtered_speed <= filt;
      out_word.angle_increment <= incr;
      out_word.code_error <= err;
    end
  end

`ifndef SYNTHESIS
  a_widx_range: assert property (@(posedge clk) disable iff (rst)
    widx < 4'(SpeedWindow))
    else $error("window index out of range");
  a_tick_no_err: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && in_word.kind) |=> !err)
    else $error("error flag on a tick");
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !kind && stat.need_speed) |=> acc == 32'd0)
    else $error("accumulator not cleared");
`endif

endmodule

>>> hdl/hall_angle_speed_estimator.sv
// Top level of the Hall angle and speed estimator.
//  channel    dir  handshake     word
//  in_ch      in   valid/ready   kind, capture_count, hall_code
//  out_ch     out  valid/ready   rotor_angle, raw_speed, filtered_speed,
//                                angle_increment, code_error
//  cfg        in   cfg_we        rotation_direction
// An edge goes straight to the result write, via the 32-step divider on the
// reference code. A tick runs the filter and increment stages, after the 45-step
// sort and mean on a full window; the next item is taken as the result appears.
// Synchronous reset clears control and most state; the window is not cleared.
// A held result word stalls only the final write of the next item's result.
module hall_angle_speed_estimator
  import hase_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  hase_stream_if.sink   in_ch,
  hase_stream_if.source out_ch
);

  logic  rotation_direction;
  cmd_t  cmd;
  stat_t stat;

  // Direction register.
  always_ff @(posedge clk) begin
    if (rst) rotation_direction <= 1'b0;
    else if (cfg_we) rotation_direction <= cfg_wdata;
  end

  hase_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  hase_dpath u_dpath (
    .clk, .rst, .rotation_direction,
    .in_word(in_ch.data), .cmd, .stat, .out_word(out_ch.data)
  );

endmodule
